[rtl/uvn_pkg.sv]
// Shared types and constants for the UTF-8 check and newline normalizer.
`timescale 1ns / 1ps

package uvn_pkg;

  // Length counter width default
  localparam int unsigned LenWidthDefault = 16;

  // Depth of the queue between the classifier and the execute stage
  localparam int unsigned QueueDepth = 2;

  // Configuration register map
  localparam int unsigned CfgAddrWidth = 3;
  localparam logic [CfgAddrWidth-1:0] ADDR_OUT_CAPACITY = 3'd0;
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // Byte codes
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_SP  = 8'h20;

  // Code point bounds
  localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
  localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] CM_BASIC_LO   = 21'h000300;
  localparam logic [20:0] CM_BASIC_HI   = 21'h00036F;
  localparam logic [20:0] CM_SUPP_LO    = 21'h001DC0;
  localparam logic [20:0] CM_SUPP_HI    = 21'h001DFF;
  localparam logic [20:0] CM_SYM_LO     = 21'h0020D0;
  localparam logic [20:0] CM_SYM_HI     = 21'h0020FF;
  localparam logic [20:0] CM_HALF_LO    = 21'h00FE20;
  localparam logic [20:0] CM_HALF_HI    = 21'h00FE2F;

  // Kind of a raw byte as seen at the start of a sequence
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_TWO,
    KIND_OVERLONG,
    KIND_THREE,
    KIND_FOUR,
    KIND_INVALID
  } byte_kind_e;

  // Reported status
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ENC  = 2'd1,
    STATUS_SIZE = 2'd2
  } status_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    byte_kind_e kind;
    logic       is_cont;
    logic       is_cr;
    logic       is_lf;
    logic       ctrl_bad;
  } cls_item_t;

  // One result
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       done;
    status_e    status;
    logic [15:0] length;
  } result_t;

endpackage

[rtl/uvn_front.sv]
// Front stage: classifies each raw byte before it enters the queue.
`timescale 1ns / 1ps

module uvn_front
  import uvn_pkg::*;
(
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output cls_item_t  item_o
);

  byte_kind_e kind;

  // Lead byte decode
  always_comb begin
    if (!in_byte_i[7]) begin
      kind = KIND_ASCII;
    end else if (in_byte_i[7:6] == 2'b10) begin
      kind = KIND_CONT;
    end else if (in_byte_i[7:5] == 3'b110) begin
      kind = (in_byte_i[4:1] == 4'd0) ? KIND_OVERLONG : KIND_TWO;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      kind = KIND_THREE;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      kind = KIND_FOUR;
    end else begin
      kind = KIND_INVALID;
    end
  end

  // CR goes out as LF, so it never counts as a control fault
  assign item_o.data     = in_byte_i;
  assign item_o.last     = last_byte_i;
  assign item_o.kind     = kind;
  assign item_o.is_cont  = (in_byte_i[7:6] == 2'b10);
  assign item_o.is_cr    = (in_byte_i == BYTE_CR);
  assign item_o.is_lf    = (in_byte_i == BYTE_LF);
  assign item_o.ctrl_bad = ((in_byte_i < BYTE_SP) && (in_byte_i != BYTE_LF)
                            && (in_byte_i != BYTE_CR)) || (in_byte_i == BYTE_DEL);

endmodule

[rtl/uvn_queue.sv]
// Short FIFO between the classifier and the execute stage.
`timescale 1ns / 1ps

module uvn_queue
  import uvn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cls_item_t pop_item_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  cls_item_t mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntWidth'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/uvn_back.sv]
// Execute stage: decoder state, newline folding, capacity and status, output register.
`timescale 1ns / 1ps

module uvn_back
  import uvn_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = LenWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] capacity_i,
  input  logic        item_valid_i,
  input  cls_item_t   item_i,
  output logic        pop_o,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_ready_i
);

  localparam int unsigned CmpWidth = 33;

  logic [1:0]           cont_left_q, cont_left_d;
  logic [1:0]           seq_len_q, seq_len_d;
  logic [20:0]          partial_q, partial_d;
  logic                 pending_cr_q, pending_cr_d;
  logic [LEN_WIDTH-1:0] count_q, count_d;
  logic                 utf8_bad_q, utf8_bad_d;
  logic                 overflow_q, overflow_d;
  logic                 content_bad_q, content_bad_d;
  logic                 res_valid_q;
  result_t              res_q, res_d;

  // Pop whenever the output register is free or drains this cycle
  assign pop_o       = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic       start;
    logic [20:0] cp;
    logic       emit;
    logic [7:0] ob;
    logic       full;

    cont_left_d   = cont_left_q;
    seq_len_d     = seq_len_q;
    partial_d     = partial_q;
    pending_cr_d  = pending_cr_q;
    count_d       = count_q;
    utf8_bad_d    = utf8_bad_q;
    overflow_d    = overflow_q;
    content_bad_d = content_bad_q;
    res_d         = '0;
    start         = 1'b0;
    cp            = '0;
    emit          = 1'b1;
    ob            = item_i.data;
    full          = 1'b0;

    // Continuation handling
    if (cont_left_q != 2'd0) begin
      if (!item_i.is_cont) begin
        utf8_bad_d  = 1'b1;
        cont_left_d = 2'd0;
        start       = 1'b1;
      end else begin
        cp          = {partial_q[14:0], item_i.data[5:0]};
        partial_d   = cp;
        cont_left_d = cont_left_q - 2'd1;
        if (cont_left_q == 2'd1) begin
          case (seq_len_q)
            2'd1: begin
              if (cp >= CM_BASIC_LO && cp <= CM_BASIC_HI) content_bad_d = 1'b1;
            end
            2'd2: begin
              if (cp < CP_MIN_3BYTE) utf8_bad_d = 1'b1;
              if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) utf8_bad_d = 1'b1;
              if ((cp >= CM_SUPP_LO && cp <= CM_SUPP_HI) ||
                  (cp >= CM_SYM_LO && cp <= CM_SYM_HI) ||
                  (cp >= CM_HALF_LO && cp <= CM_HALF_HI)) content_bad_d = 1'b1;
            end
            default: begin
              if (cp < CP_MIN_4BYTE || cp > CP_MAX) utf8_bad_d = 1'b1;
            end
          endcase
        end
      end
    end else begin
      start = 1'b1;
    end

    // Lead byte handling
    if (start) begin
      case (item_i.kind)
        KIND_ASCII: ;
        KIND_TWO: begin
          seq_len_d = 2'd1; cont_left_d = 2'd1; partial_d = {16'd0, item_i.data[4:0]};
        end
        KIND_THREE: begin
          seq_len_d = 2'd2; cont_left_d = 2'd2; partial_d = {17'd0, item_i.data[3:0]};
        end
        KIND_FOUR: begin
          seq_len_d = 2'd3; cont_left_d = 2'd3; partial_d = {18'd0, item_i.data[2:0]};
        end
        default: utf8_bad_d = 1'b1;
      endcase
    end

    // CR and CRLF fold to LF
    if (item_i.is_cr) begin
      ob           = BYTE_LF;
      pending_cr_d = 1'b1;
    end else begin
      if (item_i.is_lf && pending_cr_q) emit = 1'b0;
      pending_cr_d = 1'b0;
    end

    // Capacity check and content check on emitted bytes
    if (emit) begin
      full = (CmpWidth'(count_q) >= CmpWidth'(capacity_i)) || (&count_q);
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d    = count_q + 1'b1;
        res_d.valid = 1'b1;
        res_d.data  = ob;
      end
      if (item_i.ctrl_bad) content_bad_d = 1'b1;
    end

    // End of message: report and clear
    if (item_i.last) begin
      if (cont_left_d != 2'd0) utf8_bad_d = 1'b1;
      res_d.done = 1'b1;
      if (utf8_bad_d) begin
        res_d.status = STATUS_ENC;
      end else if (overflow_d) begin
        res_d.status = STATUS_SIZE;
      end else if (content_bad_d) begin
        res_d.status = STATUS_ENC;
      end else begin
        res_d.status = STATUS_OK;
        res_d.length = 16'(count_d);
      end
      cont_left_d   = '0;
      seq_len_d     = '0;
      partial_d     = '0;
      pending_cr_d  = 1'b0;
      count_d       = '0;
      utf8_bad_d    = 1'b0;
      overflow_d    = 1'b0;
      content_bad_d = 1'b0;
    end
  end

  // Message state, advanced once per popped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_left_q   <= '0;
      seq_len_q     <= '0;
      partial_q     <= '0;
      pending_cr_q  <= 1'b0;
      count_q       <= '0;
      utf8_bad_q    <= 1'b0;
      overflow_q    <= 1'b0;
      content_bad_q <= 1'b0;
    end else if (pop_o) begin
      cont_left_q   <= cont_left_d;
      seq_len_q     <= seq_len_d;
      partial_q     <= partial_d;
      pending_cr_q  <= pending_cr_d;
      count_q       <= count_d;
      utf8_bad_q    <= utf8_bad_d;
      overflow_q    <= overflow_d;
      content_bad_q <= content_bad_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop_o) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/utf8_validate_normalise_newlines_core.sv]
// Top level: UTF-8 check with CR/CRLF to LF folding and output length limit.
`timescale 1ns / 1ps

// Takes one raw byte per transaction on the slave stream (tlast marks the last
// byte of a message) and returns exactly one result per byte on the master
// stream, at one byte per clock cycle sustained while m_axis_tready holds high:
// a classifier feeds a two-entry queue, and the execute stage updates the
// decoder state and the output register once per popped byte. tuser carries
// out_valid; a result with tlast set carries the message status, and out_length
// is nonzero only when that status is ok. Bytes emitted for a message whose
// status is not ok are to be discarded. out_capacity (APB address 0) may only
// be written while the block is idle.
module utf8_validate_normalise_newlines_core
  import uvn_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = LenWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Raw bytes
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] in_byte
  input  logic                    s_axis_tlast,   // last_byte
  // Results
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                                  // [25:10] out_length, rest zero
  output logic                    m_axis_tlast,   // done_res
  output logic                    m_axis_tuser,   // out_valid
  // Configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] capacity_q;
  cls_item_t   front_item;
  cls_item_t   q_item;
  logic        q_full, q_valid, q_pop;
  logic        push;
  result_t     res;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_OUT_CAPACITY)) begin
      capacity_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == ADDR_OUT_CAPACITY) ? {16'd0, capacity_q} : 32'd0;

  // Front: classify
  uvn_front u_front (
    .in_byte_i   (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .item_o      (front_item)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  uvn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  // Back: execute
  uvn_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  // Result packing
  assign m_axis_tdata = {6'd0, res.length, res.status, res.data};
  assign m_axis_tlast = res.done;
  assign m_axis_tuser = res.valid;

endmodule

[rtl/uvn_checker.sv]
// Port-level checker for the core, attached by bind.
`timescale 1ns / 1ps

module uvn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Status code 3 is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3)
    else $error("undefined status");

  // Mid-message results carry no status or length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[25:8] == 18'd0)
    else $error("status or length on a non-final result");

  // A failed message reports no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[9:8] != 2'd0
      |-> m_axis_tdata[25:10] == 16'd0)
    else $error("length reported with a fault");

  // A suppressed byte reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("data on a result without a byte");

endmodule

bind utf8_validate_normalise_newlines_core uvn_checker u_uvn_checker (.*);

[tb/utf8_validate_normalise_newlines_core_test.sv]
// Testbench for the UTF-8 check and newline folding core: stream driver, checker, APB setup.
`timescale 1ns / 1ps

module utf8_validate_normalise_newlines_core_test;
  import uvn_pkg::*;

  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseBytes  = 110;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] in_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] out_byte, [9:8] status, [25:10] out_length
  logic        m_axis_tlast;        // done_res
  logic        m_axis_tuser;        // out_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Raw bytes waiting to be sent and normalized results waiting to arrive
  src_item_t   src_bytes[$];
  result_t     norm_due[$];
  logic [7:0]  msg_bytes[$];

  // Predictor state: decoder, newline folding, length and fault flags
  logic [15:0] capacity_model = CAPACITY_RESET;
  logic [1:0]  dec_left = '0;
  logic [1:0]  dec_len = '0;
  logic [20:0] dec_code = '0;
  logic        cr_seen = 1'b0;
  logic [15:0] emitted_count = '0;
  logic        enc_fault = 1'b0;
  logic        size_fault = 1'b0;
  logic        text_fault = 1'b0;

  // Traffic shaping
  logic        calm = 1'b0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_count = 0;
  int          rx_stall = 0;
  int          tx_gap = 0;
  logic        tx_valid_next;
  src_item_t   tx_item;
  result_t     rx_want;
  int          mismatches = 0;
  int          cycles = 0;

  utf8_validate_normalise_newlines_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lead byte: start a multibyte sequence or flag a bad lead
  function automatic void open_sequence(logic [7:0] b);
    if (b[7] == 1'b0) begin
      return;
    end
    if (b[7:5] == 3'b110) begin
      if (b[4:1] == 4'd0) begin
        enc_fault = 1'b1;
      end else begin
        dec_len = 2'd1; dec_left = 2'd1; dec_code = {16'd0, b[4:0]};
      end
    end else if (b[7:4] == 4'b1110) begin
      dec_len = 2'd2; dec_left = 2'd2; dec_code = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      dec_len = 2'd3; dec_left = 2'd3; dec_code = {18'd0, b[2:0]};
    end else begin
      enc_fault = 1'b1;
    end
  endfunction

  // Expected result for one raw byte; advances the predictor state
  function automatic result_t fold_and_check(logic [7:0] b, logic last);
    result_t    r;
    logic       emit;
    logic [7:0] ob;
    r    = '0;
    emit = 1'b1;
    ob   = b;

    // UTF-8 decode
    if (dec_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        enc_fault = 1'b1;
        dec_left  = 2'd0;
        open_sequence(b);
      end else begin
        dec_code = {dec_code[14:0], b[5:0]};
        dec_left = dec_left - 2'd1;
        if (dec_left == 2'd0) begin
          if (dec_len == 2'd1) begin
            if (dec_code >= CM_BASIC_LO && dec_code <= CM_BASIC_HI) text_fault = 1'b1;
          end else if (dec_len == 2'd2) begin
            if (dec_code < CP_MIN_3BYTE) enc_fault = 1'b1;
            if (dec_code >= CP_SURR_LO && dec_code <= CP_SURR_HI) enc_fault = 1'b1;
            if ((dec_code >= CM_SUPP_LO && dec_code <= CM_SUPP_HI) ||
                (dec_code >= CM_SYM_LO && dec_code <= CM_SYM_HI) ||
                (dec_code >= CM_HALF_LO && dec_code <= CM_HALF_HI)) text_fault = 1'b1;
          end else begin
            if (dec_code < CP_MIN_4BYTE || dec_code > CP_MAX) enc_fault = 1'b1;
          end
        end
      end
    end else begin
      open_sequence(b);
    end

    // CR becomes LF, LF right after CR is swallowed
    if (b == BYTE_CR) begin
      ob      = BYTE_LF;
      cr_seen = 1'b1;
    end else begin
      if (b == BYTE_LF && cr_seen) emit = 1'b0;
      cr_seen = 1'b0;
    end

    if (emit) begin
      if (emitted_count >= capacity_model || emitted_count == CountMax) begin
        size_fault = 1'b1;
      end else begin
        emitted_count = emitted_count + 16'd1;
        r.valid = 1'b1;
        r.data  = ob;
      end
      if ((ob < BYTE_SP && ob != BYTE_LF) || ob == BYTE_DEL) text_fault = 1'b1;
    end

    // End of message: status by priority, then clear
    if (last) begin
      if (dec_left != 2'd0) enc_fault = 1'b1;
      r.done = 1'b1;
      if (enc_fault) r.status = STATUS_ENC;
      else if (size_fault) r.status = STATUS_SIZE;
      else if (text_fault) r.status = STATUS_ENC;
      else begin
        r.status = STATUS_OK;
        r.length = emitted_count;
      end
      dec_left = '0; dec_len = '0; dec_code = '0; cr_seen = 1'b0;
      emitted_count = '0; enc_fault = 1'b0; size_fault = 1'b0; text_fault = 1'b0;
    end
    return r;
  endfunction

  // Stimulus builders
  function automatic void put_raw(logic [7:0] b, logic l);
    src_bytes.push_back('{data: b, last: l});
  endfunction

  function automatic int natural_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encode cp in n bytes, keep only the first keep of them
  function automatic void put_code(logic [20:0] cp, int n, int keep);
    logic [7:0] b[4];
    case (n)
      1: b[0] = cp[7:0];
      2: begin
        b[0] = {3'b110, cp[10:6]}; b[1] = {2'b10, cp[5:0]};
      end
      3: begin
        b[0] = {4'b1110, cp[15:12]}; b[1] = {2'b10, cp[11:6]}; b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        b[0] = {5'b11110, cp[20:18]}; b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};     b[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) msg_bytes.push_back(b[i]);
  endfunction

  function automatic void put_char(logic [20:0] cp);
    put_code(cp, natural_len(cp), natural_len(cp));
  endfunction

  // One message of random tokens, mostly well-formed text
  function automatic void add_message();
    int          tokens;
    int          n;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    msg_bytes.delete();
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        5: msg_bytes.push_back(BYTE_CR);
        6: msg_bytes.push_back(BYTE_LF);
        7: begin
          msg_bytes.push_back(BYTE_CR); msg_bytes.push_back(BYTE_LF);
        end
        8: msg_bytes.push_back($urandom_range(0, 1) ? BYTE_DEL : 8'($urandom_range(0, 8'h1F)));
        9: put_char(21'($urandom_range(21'h80, 21'h7FF)));
        10: put_char(21'($urandom_range(21'h800, 21'hFFFF)));
        11: begin
          // combining marks and surrogates, edges included
          case ($urandom_range(0, 4))
            0: begin lo = CM_BASIC_LO; hi = CM_BASIC_HI; end
            1: begin lo = CM_SUPP_LO; hi = CM_SUPP_HI; end
            2: begin lo = CM_SYM_LO; hi = CM_SYM_HI; end
            3: begin lo = CM_HALF_LO; hi = CM_HALF_HI; end
            default: begin lo = CP_SURR_LO; hi = CP_SURR_HI; end
          endcase
          put_char(21'($urandom_range(lo - 21'd1, hi + 21'd1)));
        end
        12: put_char(21'($urandom_range(21'h10000, 21'h10FFFF)));
        13: begin
          if ($urandom_range(0, 1)) begin
            cp = 21'($urandom_range(0, 21'h7FF));
            n  = $urandom_range(natural_len(cp) + 1, 4);
            put_code(cp, n, n);
          end else begin
            put_code(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
          end
        end
        14: begin
          // sequence cut short
          cp = 21'($urandom_range(21'h80, 21'h10FFFF));
          n  = natural_len(cp);
          put_code(cp, n, $urandom_range(1, n - 1));
        end
        default: msg_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    foreach (msg_bytes[i]) put_raw(msg_bytes[i], i == msg_bytes.size() - 1);
  endfunction

  // Sender: offers queued bytes, predicts each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        norm_due.push_back(fold_and_check(s_axis_tdata, s_axis_tlast));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        tx_valid_next = 1'b0;
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (src_bytes.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 13);
        end else if (src_bytes.size() > 0) begin
          tx_item = src_bytes.pop_front();
          tx_valid_next = 1'b1;
          s_axis_tdata <= tx_item.data;
          s_axis_tlast <= tx_item.last;
        end
        s_axis_tvalid <= tx_valid_next;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: compares each result transaction, then decides next tready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (norm_due.size() == 0) begin
          $error("unexpected result: tdata %0h tlast %0b tuser %0b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatches++;
        end else begin
          rx_want = norm_due.pop_front();
          check_field("out_valid", rx_want.valid, m_axis_tuser);
          check_field("out_byte", rx_want.data, m_axis_tdata[7:0]);
          check_field("done_res", rx_want.done, m_axis_tlast);
          check_field("status", rx_want.status, m_axis_tdata[9:8]);
          check_field("out_length", rx_want.length, m_axis_tdata[25:10]);
          check_field("tdata padding", 0, m_axis_tdata[31:26]);
        end
      end
      // one long hold-off once armed, otherwise random stall bursts unless calm
      if (hold_armed && !hold_done) begin
        hold_count = hold_count + 1;
        if (hold_count >= HoldCycles) hold_done = 1'b1;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_capacity(input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_OUT_CAPACITY;
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_model = value;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (src_bytes.size() != 0 || s_axis_tvalid || norm_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Phases: directed bytes, then random messages at several capacities
  initial begin
    logic [15:0] caps[6];
    caps = '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'($urandom_range(2, 40)), 16'hFFFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // CR LF swallowed, CR CR, plain letter
    put_raw(BYTE_CR, 0); put_raw(BYTE_LF, 0); put_raw(BYTE_CR, 0); put_raw(BYTE_CR, 0);
    put_raw(8'h41, 1);
    // bad lead and a forbidden control byte
    put_raw(8'hFF, 1);
    put_raw(8'h00, 1);
    // smallest two-byte form, then an overlong one
    put_raw(8'hC2, 0); put_raw(8'h80, 1);
    put_raw(8'hC0, 0); put_raw(8'hAF, 1);
    // surrogate
    put_raw(8'hED, 0); put_raw(8'hA0, 0); put_raw(8'h80, 1);
    // combining mark
    put_raw(8'hCC, 0); put_raw(8'h80, 1);
    // above 10FFFF
    put_raw(8'hF4, 0); put_raw(8'h90, 0); put_raw(8'h80, 0); put_raw(8'h80, 1);
    // cut off at the end of the message
    put_raw(8'hE2, 0); put_raw(8'h82, 1);
    // broken sequence restarts on a new lead, then DEL
    put_raw(8'hC2, 0); put_raw(8'h41, 0); put_raw(BYTE_DEL, 1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      @(negedge clk_i);
      if (p == 3) hold_armed = 1'b1;
      if (p == 5) calm = 1'b1;
      while (src_bytes.size() < PhaseBytes) add_message();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && norm_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
